### hw/rtl/mosk_pkg.sv
// ----------------------------------------------------------------------------
// mosk_pkg: shared definitions for the organ stop and key relay
// Sizes, MIDI codes, sequencer step codes and the microcode table.
// ----------------------------------------------------------------------------
package mosk_pkg;

  // Organ geometry
  localparam int STOPS   = 3;
  localparam int OCTAVES = 7;
  localparam int OCT_W   = $clog2(OCTAVES);

  // Field widths fixed by the stream format
  localparam int BYTE_W  = 8;
  localparam int DATA7_W = 7;
  localparam int STOP_W  = 2;
  localparam int POCT_W  = 3;
  localparam int BITS_W  = 12;
  localparam int OUT_W   = 24;
  localparam int CHAN_W  = 4;

  // Pipe octaves carried in a frame, and the partial top octave
  localparam logic [POCT_W-1:0] POCT_FIRST = 3'd3;
  localparam logic [POCT_W-1:0] POCT_LAST  = 3'd6;
  localparam logic [BITS_W-1:0] TOP_MASK   = 12'h03F;
  localparam logic [STOP_W-1:0] STOP_LAST  = STOP_W'(STOPS - 1);

  // Key numbers that map onto key bits
  localparam logic [DATA7_W-1:0] KEY_LOW  = 7'd36;
  localparam logic [DATA7_W-1:0] KEY_HIGH = DATA7_W'(OCTAVES * 12);

  // Octave of a key number: (k * 43) >> 9 equals k / 12 for every 7-bit k
  localparam int KEY_RECIP    = 43;
  localparam int KEY_RECIP_SH = 9;

  // Stop notes: low three bits 2..6 give a stop's octave shift, centre 4
  localparam logic [2:0] STOP_NOTE_LO = 3'd2;
  localparam logic [2:0] STOP_NOTE_HI = 3'd6;
  localparam logic [2:0] STOP_CENTRE  = 3'd4;

  // MIDI command field of a status byte and the two note commands
  localparam logic [DATA7_W-1:0] CMD_FIELD    = 7'h70;
  localparam logic [DATA7_W-1:0] CMD_NOTE_OFF = 7'h00;
  localparam logic [DATA7_W-1:0] CMD_NOTE_ON  = 7'h10;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_CHANNEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_CHANNEL  = 1'd1;

  // Parser phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FIRST = 2'd1;
  localparam logic [1:0] PH_LAST  = 2'd2;

  // Sequencer steps
  localparam int STEP_W = 2;
  localparam logic [STEP_W-1:0] STEP_FETCH = 2'd0;
  localparam logic [STEP_W-1:0] STEP_EXEC  = 2'd1;
  localparam logic [STEP_W-1:0] STEP_EMIT  = 2'd2;

  // Jump conditions; when false the step repeats
  localparam logic [1:0] COND_ALWAYS   = 2'd0;
  localparam logic [1:0] COND_MSG_DONE = 2'd1;
  localparam logic [1:0] COND_FRAME    = 2'd2;

  typedef struct packed {
    logic              accept;
    logic              update;
    logic              emit;
    logic [1:0]        cond;
    logic [STEP_W-1:0] target;
  } ctl_word_t;

  // Microcode table: one control word per step.
  function automatic ctl_word_t ucode_rom(input logic [STEP_W-1:0] step);
    ctl_word_t w;
    w = '0;
    case (step)
      STEP_FETCH: begin
        w.accept = 1'b1;
        w.cond   = COND_MSG_DONE;
        w.target = STEP_EXEC;
      end
      STEP_EXEC: begin
        w.update = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_FRAME;
        w.target = STEP_FETCH;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/midi_organ_stop_key_relay.sv
// ----------------------------------------------------------------------------
// midi_organ_stop_key_relay: MIDI note relay for a three-stop pipe organ
// Parses MIDI bytes, keeps key and stop state and emits a pipe frame after
// every complete three-byte message.
// ----------------------------------------------------------------------------
// Status and first data bytes are taken while the sequencer is in its fetch
// step. The byte that completes a message leads to the state update step,
// and the frame of twelve words then leaves at one word per cycle while the
// sink takes them; the next byte is accepted only after the last word of the
// frame has entered the output register. A small microcode table steps the
// sequencer through fetch, update and emit; the emit step repeats until the
// last word of the frame is loaded. The last word of a frame may still wait
// in the output register while the next bytes are accepted.
module midi_organ_stop_key_relay
  import mosk_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Input stream; tdata: midi_byte [7:0]
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [BYTE_W-1:0]    s_tdata,
  // Output stream; tdata: stop_index [1:0], pipe_octave [4:2],
  // pipe_bits [16:5], zero fill [23:17]; tlast: last_of_frame
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,
  output logic                 m_tlast,
  // Configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CHAN_W-1:0]    cfg_data
);

  // Configuration registers
  logic [CHAN_W-1:0] stop_ch;
  logic [CHAN_W-1:0] key_ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_ch <= '0;
      key_ch  <= CHAN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STOP_CHANNEL: stop_ch <= cfg_data;
        CFG_KEY_CHANNEL:  key_ch  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: step counter and the control word it selects
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ctl_word_t         ctl;
  logic              cond_true;

  assign ctl = ucode_rom(step);

  // Parser registers
  logic [1:0]         phase;
  logic [DATA7_W-1:0] status_low;
  logic [DATA7_W-1:0] first_data;
  logic               in_fire;
  logic               is_status;
  logic               msg_done;

  assign s_tready  = ctl.accept && !rst;
  assign in_fire   = s_tvalid && s_tready;
  assign is_status = s_tdata[BYTE_W-1];
  assign msg_done  = in_fire && !is_status && (phase == PH_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      status_low <= '0;
      first_data <= '0;
    end else if (in_fire) begin
      if (is_status) begin
        status_low <= s_tdata[DATA7_W-1:0];
        phase      <= PH_FIRST;
      end else begin
        case (phase)
          PH_FIRST: begin
            first_data <= s_tdata[DATA7_W-1:0];
            phase      <= PH_LAST;
          end
          PH_LAST:  phase <= PH_IDLE;
          default:  ;
        endcase
      end
    end
  end

  // Message decode from the stored status and first data byte
  logic [DATA7_W-1:0]     cmd;
  logic                   is_note;
  logic                   note_on;
  logic                   stop_msg;
  logic                   key_msg;
  logic                   stop_note_ok;
  logic [2:0]             shift_new;
  logic                   key_ok;
  logic [12:0]            key_prod;
  logic [3:0]             key_oct;
  logic [3:0]             key_semi;
  logic [7:0]             oct_base;

  always_comb begin
    cmd          = status_low & CMD_FIELD;
    is_note      = (cmd == CMD_NOTE_ON) || (cmd == CMD_NOTE_OFF);
    note_on      = (cmd == CMD_NOTE_ON);
    stop_msg     = is_note && (status_low[3:0] == stop_ch);
    key_msg      = is_note && (status_low[3:0] != stop_ch)
                   && (status_low[3:0] == key_ch);
    stop_note_ok = first_data[2:0] inside {[STOP_NOTE_LO:STOP_NOTE_HI]};
    shift_new    = first_data[2:0] - STOP_CENTRE;
    key_ok       = (first_data >= KEY_LOW) && (first_data < KEY_HIGH);
    key_prod     = 13'(first_data) * 13'(KEY_RECIP);
    key_oct      = 4'(key_prod >> KEY_RECIP_SH);
    oct_base     = 8'(key_oct) * 8'd12;
    key_semi     = 4'(8'(first_data) - oct_base);
  end

  // Stop state: one on flag and a signed octave shift per stop
  logic       stop_on    [STOPS];
  logic [2:0] stop_shift [STOPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < STOPS; s++) begin
        stop_on[s]    <= 1'b0;
        stop_shift[s] <= '0;
      end
    end else if (ctl.update && stop_msg && stop_note_ok) begin
      for (int s = 0; s < STOPS; s++) begin
        if (first_data[6:3] == 4'(s)) begin
          stop_on[s]    <= note_on;
          stop_shift[s] <= note_on ? shift_new : 3'd0;
        end
      end
    end
  end

  // Key state: one twelve-bit word per octave
  logic [BITS_W-1:0] key_bits [OCTAVES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int o = 0; o < OCTAVES; o++) begin
        key_bits[o] <= '0;
      end
    end else if (ctl.update && key_msg && key_ok) begin
      for (int o = 0; o < OCTAVES; o++) begin
        if (key_oct == 4'(o)) begin
          key_bits[o][key_semi] <= note_on;
        end
      end
    end
  end

  // Frame word counters
  logic [STOP_W-1:0] word_stop;
  logic [POCT_W-1:0] word_oct;
  logic              word_last;
  logic              out_fire;
  logic              frame_done;

  assign word_last  = (word_stop == STOP_LAST) && (word_oct == POCT_LAST);
  assign out_fire   = ctl.emit && (!m_tvalid || m_tready);
  assign frame_done = out_fire && word_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_stop <= '0;
      word_oct  <= POCT_FIRST;
    end else if (ctl.update) begin
      word_stop <= '0;
      word_oct  <= POCT_FIRST;
    end else if (out_fire) begin
      if (word_oct == POCT_LAST) begin
        word_oct  <= POCT_FIRST;
        word_stop <= word_last ? '0 : word_stop + 1'b1;
      end else begin
        word_oct <= word_oct + 1'b1;
      end
    end
  end

  // Pipe bits of the current word: source octave is pipe octave minus shift
  logic [3:0]        src_oct;
  logic [BITS_W-1:0] word_bits;

  always_comb begin
    src_oct   = {1'b0, word_oct} - {stop_shift[word_stop][2], stop_shift[word_stop]};
    word_bits = '0;
    if (stop_on[word_stop] && (src_oct < 4'(OCTAVES))) begin
      word_bits = key_bits[src_oct[OCT_W-1:0]];
    end
    if (word_oct == POCT_LAST) begin
      word_bits = word_bits & TOP_MASK;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      m_tdata <= {7'd0, word_bits, word_oct, word_stop};
      m_tlast <= word_last;
    end
  end

  // Sequencer step update from the control word's condition
  always_comb begin
    case (ctl.cond)
      COND_ALWAYS:   cond_true = 1'b1;
      COND_MSG_DONE: cond_true = msg_done;
      COND_FRAME:    cond_true = frame_done;
      default:       cond_true = 1'b0;
    endcase
    step_next = cond_true ? ctl.target : step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_FETCH;
    end else begin
      step <= step_next;
    end
  end

`ifndef ASSERT_OFF
  // The update step is always followed by the emit step.
  assert property (@(posedge clk) disable iff (rst)
    (step == STEP_EXEC) |=> (step == STEP_EMIT))
    else $error("update step not followed by emit");

  // A completing data byte leads straight to the update step.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tdata[7] && phase == PH_LAST) |=> (step == STEP_EXEC))
    else $error("completed message did not start an update");

  // The last word of a frame carries the last stop and the top octave.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[1:0] == STOP_LAST && m_tdata[4:2] == POCT_LAST))
    else $error("frame end on wrong word");
`endif

endmodule
